// File: rtl/crsd_pkg.sv
// Shared types and constants for the cube record stream decoder.
// No dependencies; the top level, the parser and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package crsd_pkg;

    localparam int MAX_THRESHOLDS = 128;
    localparam int SLOT_W         = $clog2(MAX_THRESHOLDS);
    localparam int BYTE_W         = 8;
    localparam int SIZE_W         = 16;
    localparam int COMP_W         = 5;
    localparam int KIND_W         = 3;

    localparam logic [BYTE_W-1:0] RUN_MARK = 8'h80;
    localparam logic [BYTE_W-1:0] RUN_MASK = 8'h7f;

    localparam logic [COMP_W-1:0] POLY_BYTES_ONE   = 5'd12;
    localparam logic [COMP_W-1:0] POLY_BYTES_THREE = 5'd18;

    typedef enum logic [KIND_W-1:0] {
        KIND_RUN     = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_SIZE    = 3'd2,
        KIND_COUNT   = 3'd3,
        KIND_INDEX   = 3'd4,
        KIND_POLY    = 3'd5,
        KIND_SURPLUS = 3'd6,
        KIND_ZERO    = 3'd7
    } kind_t;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_SIZE_HI = 7'b0000010,
        PH_SIZE_LO = 7'b0000100,
        PH_COUNTS  = 7'b0001000,
        PH_INDICES = 7'b0010000,
        PH_POLYS   = 7'b0100000,
        PH_SURPLUS = 7'b1000000
    } phase_t;

    // One entry of the slot chain: the next slot with polygons and its count.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] count;
    } link_t;

    localparam int LINK_W = $bits(link_t);

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        link_t             data;
    } link_wr_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] value;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] polygon;
        logic [COMP_W-1:0] component;
        logic              record_end;
        logic              short_record;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/cube_record_stream_decoder.sv
// Top level of the cube record stream decoder: input and result registers,
// configuration register and the slot chain memory. Depends on crsd_pkg,
// crsd_ram and crsd_parser.
`timescale 1ns / 1ps
`default_nettype none

// Every input word yields exactly one tagged result word. The block sustains one
// word per clock while the output is not stalled; each accepted word passes the
// input register and then the result register, with the combinational decode
// between the two. Slots with polygons are chained in a 128-entry memory while
// the counts arrive, and the next slot's entry is read ahead while the current
// slot's polygon words pass, so no search and no clearing pass after reset is
// needed. Write three_normals only while the block is idle.
module cube_record_stream_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [crsd_pkg::BYTE_W-1:0] data_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [crsd_pkg::KIND_W-1:0]      item_kind,
    output logic [crsd_pkg::BYTE_W-1:0]      value,
    output logic [crsd_pkg::SLOT_W-1:0]      slot,
    output logic [crsd_pkg::BYTE_W-1:0]      polygon,
    output logic [crsd_pkg::COMP_W-1:0]      component,
    output logic                             record_end,
    output logic                             short_record
);

    import crsd_pkg::*;

    logic               three_normals_reg;
    logic               s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg;
    result_t            result;
    logic               advance;
    logic               in_accept;
    logic [SLOT_W-1:0]  link_raddr;
    link_wr_t           link_wr;
    logic [LINK_W-1:0]  link_rdata;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_normals_reg <= 1'b0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                three_normals_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    crsd_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .data_byte     (s1_byte_reg),
        .three_normals (three_normals_reg),
        .link_rdata    (link_t'(link_rdata)),
        .link_raddr    (link_raddr),
        .link_wr       (link_wr),
        .result        (result)
    );

    crsd_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_THRESHOLDS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_wr.en),
        .waddr (link_wr.addr),
        .wdata (link_wr.data),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign item_kind    = result_reg.kind;
    assign value        = result_reg.value;
    assign slot         = result_reg.slot;
    assign polygon      = result_reg.polygon;
    assign component    = result_reg.component;
    assign record_end   = result_reg.record_end;
    assign short_record = result_reg.short_record;

endmodule

`default_nettype wire

// File: rtl/crsd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module crsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/crsd_parser.sv
// Record parser: phase state, cursors and the per-word decode of the stream.
// Depends on crsd_pkg; the slot chain lives in a crsd_ram owned by the top level.
`timescale 1ns / 1ps
`default_nettype none

module crsd_parser (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,
    input  wire logic [crsd_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       three_normals,
    input  wire crsd_pkg::link_t            link_rdata,
    output logic [crsd_pkg::SLOT_W-1:0]     link_raddr,
    output crsd_pkg::link_wr_t              link_wr,
    output crsd_pkg::result_t               result
);

    import crsd_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [SLOT_W-1:0]   thr_reg, thr_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SIZE_W-1:0]   seen_reg, seen_next;
    logic [SLOT_W-1:0]   slot_cur_reg, slot_cur_next;
    logic [BYTE_W-1:0]   poly_cur_reg, poly_cur_next;
    logic [COMP_W-1:0]   comp_cur_reg, comp_cur_next;
    logic [BYTE_W-1:0]   cur_count_reg, cur_count_next;
    logic                have_filled_reg, have_filled_next;
    logic [SLOT_W-1:0]   prev_filled_reg, prev_filled_next;
    logic [SLOT_W-1:0]   first_slot_reg, first_slot_next;
    logic [BYTE_W-1:0]   first_count_reg, first_count_next;

    logic [COMP_W-1:0]   per;
    logic                more_slots;
    logic                body;
    logic [SIZE_W-1:0]   size_full;
    logic [SIZE_W-1:0]   seen_inc;

    assign per        = three_normals ? POLY_BYTES_THREE : POLY_BYTES_ONE;
    assign more_slots = ({1'b0, slot_cur_reg} + 8'd1) < {1'b0, thr_reg};
    assign size_full  = {size_reg[SIZE_W-1:BYTE_W], data_byte};
    assign seen_inc   = seen_reg + 16'd1;
    assign link_raddr = slot_cur_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        thr_next         = thr_reg;
        size_next        = size_reg;
        seen_next        = seen_reg;
        slot_cur_next    = slot_cur_reg;
        poly_cur_next    = poly_cur_reg;
        comp_cur_next    = comp_cur_reg;
        cur_count_next   = cur_count_reg;
        have_filled_next = have_filled_reg;
        prev_filled_next = prev_filled_reg;
        first_slot_next  = first_slot_reg;
        first_count_next = first_count_reg;
        body             = 1'b0;

        link_wr.en        = 1'b0;
        link_wr.addr      = prev_filled_reg;
        link_wr.data.slot = slot_cur_reg;
        link_wr.data.count = data_byte;

        result.kind         = KIND_RUN;
        result.value        = data_byte;
        result.slot         = '0;
        result.polygon      = '0;
        result.component    = '0;
        result.record_end   = 1'b0;
        result.short_record = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if ((data_byte & RUN_MARK) != '0)
                begin
                    result.kind       = KIND_RUN;
                    result.value      = data_byte & RUN_MASK;
                    result.record_end = 1'b1;
                end
                else
                begin
                    result.kind = KIND_HEADER;
                    thr_next    = data_byte[SLOT_W-1:0];
                    phase_next  = PH_SIZE_HI;
                end
            end
            PH_SIZE_HI:
            begin
                result.kind = KIND_SIZE;
                size_next   = {data_byte, 8'h00};
                phase_next  = PH_SIZE_LO;
            end
            PH_SIZE_LO:
            begin
                size_next        = size_full;
                seen_next        = '0;
                slot_cur_next    = '0;
                poly_cur_next    = '0;
                comp_cur_next    = '0;
                have_filled_next = 1'b0;
                if (size_full == '0)
                begin
                    result.kind         = KIND_ZERO;
                    result.record_end   = 1'b1;
                    result.short_record = (thr_reg != '0);
                    phase_next          = PH_IDLE;
                end
                else
                begin
                    result.kind = KIND_SIZE;
                    phase_next  = (thr_reg != '0) ? PH_COUNTS : PH_SURPLUS;
                end
            end
            PH_COUNTS:
            begin
                body        = 1'b1;
                result.kind = KIND_COUNT;
                result.slot = slot_cur_reg;
                if (data_byte != '0)
                begin
                    if (have_filled_reg)
                    begin
                        link_wr.en = 1'b1;
                    end
                    else
                    begin
                        first_slot_next  = slot_cur_reg;
                        first_count_next = data_byte;
                    end
                    have_filled_next = 1'b1;
                    prev_filled_next = slot_cur_reg;
                end
                if (more_slots)
                begin
                    slot_cur_next = slot_cur_reg + 7'd1;
                end
                else
                begin
                    slot_cur_next = '0;
                    phase_next    = PH_INDICES;
                end
            end
            PH_INDICES:
            begin
                body        = 1'b1;
                result.kind = KIND_INDEX;
                result.slot = slot_cur_reg;
                if (more_slots)
                begin
                    slot_cur_next = slot_cur_reg + 7'd1;
                end
                else
                begin
                    poly_cur_next = '0;
                    comp_cur_next = '0;
                    if (have_filled_reg)
                    begin
                        phase_next     = PH_POLYS;
                        slot_cur_next  = first_slot_reg;
                        cur_count_next = first_count_reg;
                    end
                    else
                    begin
                        phase_next    = PH_SURPLUS;
                        slot_cur_next = '0;
                    end
                end
            end
            PH_POLYS:
            begin
                body             = 1'b1;
                result.kind      = KIND_POLY;
                result.slot      = slot_cur_reg;
                result.polygon   = poly_cur_reg;
                result.component = comp_cur_reg;
                if ((comp_cur_reg + 5'd1) < per)
                begin
                    comp_cur_next = comp_cur_reg + 5'd1;
                end
                else if (({1'b0, poly_cur_reg} + 9'd1) < {1'b0, cur_count_reg})
                begin
                    comp_cur_next = '0;
                    poly_cur_next = poly_cur_reg + 8'd1;
                end
                else
                begin
                    comp_cur_next = '0;
                    poly_cur_next = '0;
                    if (slot_cur_reg != prev_filled_reg)
                    begin
                        slot_cur_next  = link_rdata.slot;
                        cur_count_next = link_rdata.count;
                    end
                    else
                    begin
                        phase_next    = PH_SURPLUS;
                        slot_cur_next = '0;
                    end
                end
            end
            PH_SURPLUS:
            begin
                body        = 1'b1;
                result.kind = KIND_SURPLUS;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (body)
        begin
            seen_next = seen_inc;
            if (seen_inc >= size_reg)
            begin
                result.record_end   = 1'b1;
                result.short_record = (phase_next != PH_SURPLUS);
                phase_next          = PH_IDLE;
                slot_cur_next       = '0;
                poly_cur_next       = '0;
                comp_cur_next       = '0;
            end
        end

        if (!advance)
        begin
            link_wr.en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            thr_reg         <= '0;
            size_reg        <= '0;
            seen_reg        <= '0;
            slot_cur_reg    <= '0;
            poly_cur_reg    <= '0;
            comp_cur_reg    <= '0;
            cur_count_reg   <= '0;
            have_filled_reg <= 1'b0;
            prev_filled_reg <= '0;
            first_slot_reg  <= '0;
            first_count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            thr_reg         <= thr_next;
            size_reg        <= size_next;
            seen_reg        <= seen_next;
            slot_cur_reg    <= slot_cur_next;
            poly_cur_reg    <= poly_cur_next;
            comp_cur_reg    <= comp_cur_next;
            cur_count_reg   <= cur_count_next;
            have_filled_reg <= have_filled_next;
            prev_filled_reg <= prev_filled_next;
            first_slot_reg  <= first_slot_next;
            first_count_reg <= first_count_next;
        end
    end

    a_header_to_size: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_IDLE && data_byte[7] == 1'b0
        |=> phase_reg == PH_SIZE_HI)
        else $error("header word did not lead to the size phase");

    a_chain_write_in_counts: assert property (@(posedge clk) disable iff (!rst_n)
        link_wr.en |-> phase_reg == PH_COUNTS && advance)
        else $error("slot chain written outside the count phase");

    a_comp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_POLYS |-> comp_cur_reg < POLY_BYTES_THREE)
        else $error("component cursor beyond the longest polygon");

    a_slot_in_record: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_POLYS |-> {1'b0, slot_cur_reg} < {1'b0, thr_reg})
        else $error("polygon slot beyond the record's threshold count");

endmodule

`default_nettype wire

// File: tb/cube_record_stream_decoder_test.sv
// Self-checking testbench for cube_record_stream_decoder: a directed table, then random records.
// Typed rows check against a literal result; other words against a cycle-free model in this file.
// Depends on crsd_pkg and the cube_record_stream_decoder top level.
`timescale 1ns / 1ps

module cube_record_stream_decoder_test;

    import crsd_pkg::*;

    localparam int ITEMS       = 1200;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PLAN_LEN    = 26;

    typedef struct {
        logic [BYTE_W-1:0] b;
        bit                typed;
        result_t           r;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [BYTE_W-1:0]   data_byte;
    logic                out_valid;
    logic                out_stall;
    logic [KIND_W-1:0]   item_kind;
    logic [BYTE_W-1:0]   value;
    logic [SLOT_W-1:0]   slot;
    logic [BYTE_W-1:0]   polygon;
    logic [COMP_W-1:0]   component;
    logic                record_end;
    logic                short_record;

    // Decoder model state.
    phase_t              ph = PH_IDLE;
    logic                normals3 = 1'b0;
    logic [SLOT_W-1:0]   thr_count = '0;
    logic [SIZE_W-1:0]   rec_size = '0;
    logic [SIZE_W-1:0]   body_count = '0;
    logic [BYTE_W-1:0]   poly_counts [MAX_THRESHOLDS];
    logic                has_polys [MAX_THRESHOLDS];
    logic [SLOT_W-1:0]   slot_cur = '0;
    logic [BYTE_W-1:0]   poly_cur = '0;
    logic [COMP_W-1:0]   comp_cur = '0;

    result_t             expected_words [$];
    plan_row_t           plan [PLAN_LEN];
    result_t             want;
    int                  errors = 0;
    int                  items_sent = 0;
    int                  cycles = 0;
    int                  big_left = 1;
    bit                  tx_calm = 1'b0;
    bit                  rx_calm = 1'b0;
    int unsigned         hold;
    int unsigned         stall_left = 0;

    cube_record_stream_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .item_kind    (item_kind),
        .value        (value),
        .slot         (slot),
        .polygon      (polygon),
        .component    (component),
        .record_end   (record_end),
        .short_record (short_record)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic result_t mk(input kind_t k, input logic [BYTE_W-1:0] v,
                                   input logic e, input logic s);
        result_t r;
        r = '0;
        r.kind = k;
        r.value = v;
        r.record_end = e;
        r.short_record = s;
        return r;
    endfunction

    // Moves to the first slot at or after start that has polygons, or to surplus.
    task automatic enter_slots(input int start);
        int s;
        s = -1;
        for (int i = start; i < int'(thr_count); i++)
            if (has_polys[i] && s < 0)
                s = i;
        poly_cur = '0;
        comp_cur = '0;
        if (s < 0)
        begin
            ph = PH_SURPLUS;
            slot_cur = '0;
        end
        else
        begin
            ph = PH_POLYS;
            slot_cur = s[SLOT_W-1:0];
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, output result_t r);
        bit body;
        int per;
        r = '0;
        r.value = b;
        body = 1'b0;
        case (ph)
            PH_IDLE:
            begin
                if ((b & RUN_MARK) != 0)
                begin
                    r.kind = KIND_RUN;
                    r.value = b & RUN_MASK;
                    r.record_end = 1'b1;
                end
                else
                begin
                    r.kind = KIND_HEADER;
                    thr_count = b[SLOT_W-1:0];
                    ph = PH_SIZE_HI;
                end
            end
            PH_SIZE_HI:
            begin
                r.kind = KIND_SIZE;
                rec_size = {b, 8'h00};
                ph = PH_SIZE_LO;
            end
            PH_SIZE_LO:
            begin
                rec_size = {rec_size[SIZE_W-1:BYTE_W], b};
                body_count = '0;
                slot_cur = '0;
                poly_cur = '0;
                comp_cur = '0;
                if (rec_size == 0)
                begin
                    r.kind = KIND_ZERO;
                    r.record_end = 1'b1;
                    r.short_record = (thr_count != 0);
                    ph = PH_IDLE;
                end
                else
                begin
                    r.kind = KIND_SIZE;
                    ph = (thr_count != 0) ? PH_COUNTS : PH_SURPLUS;
                end
            end
            PH_COUNTS:
            begin
                body = 1'b1;
                r.kind = KIND_COUNT;
                r.slot = slot_cur;
                poly_counts[slot_cur] = b;
                has_polys[slot_cur] = (b != 0);
                if (int'(slot_cur) + 1 < int'(thr_count))
                    slot_cur++;
                else
                begin
                    slot_cur = '0;
                    ph = PH_INDICES;
                end
            end
            PH_INDICES:
            begin
                body = 1'b1;
                r.kind = KIND_INDEX;
                r.slot = slot_cur;
                if (int'(slot_cur) + 1 < int'(thr_count))
                    slot_cur++;
                else
                    enter_slots(0);
            end
            PH_POLYS:
            begin
                per = normals3 ? int'(POLY_BYTES_THREE) : int'(POLY_BYTES_ONE);
                body = 1'b1;
                r.kind = KIND_POLY;
                r.slot = slot_cur;
                r.polygon = poly_cur;
                r.component = comp_cur;
                if (int'(comp_cur) + 1 < per)
                    comp_cur++;
                else if (int'(poly_cur) + 1 < int'(poly_counts[slot_cur]))
                begin
                    comp_cur = '0;
                    poly_cur++;
                end
                else
                    enter_slots(int'(slot_cur) + 1);
            end
            default:
            begin
                body = 1'b1;
                r.kind = KIND_SURPLUS;
                ph = PH_SURPLUS;
            end
        endcase
        if (body)
        begin
            body_count++;
            if (body_count >= rec_size)
            begin
                r.record_end = 1'b1;
                r.short_record = (ph != PH_SURPLUS);
                ph = PH_IDLE;
                slot_cur = '0;
                poly_cur = '0;
                comp_cur = '0;
            end
        end
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                             input result_t lit = '0);
        int unsigned gap;
        result_t r;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(b, r);
        expected_words.push_back(typed ? lit : r);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        normals3 = v;
    endtask

    task automatic send_record();
        int nthr;
        int per;
        int layout;
        int size;
        int mode;
        int pc [MAX_THRESHOLDS];
        logic [BYTE_W-1:0] b;
        nthr = ($urandom_range(0, 99) < 4) ? $urandom_range(5, 127) : $urandom_range(0, 4);
        per = normals3 ? int'(POLY_BYTES_THREE) : int'(POLY_BYTES_ONE);
        layout = 2 * nthr;
        for (int i = 0; i < nthr; i++)
        begin
            if (nthr > 4)
                pc[i] = ($urandom_range(0, 99) < 80) ? 0 : $urandom_range(1, 2);
            else if (big_left > 0 && $urandom_range(0, 99) < 4)
            begin
                pc[i] = $urandom_range(20, 60);
                big_left--;
            end
            else
                pc[i] = $urandom_range(0, 3);
            layout += pc[i] * per;
        end
        mode = $urandom_range(0, 99);
        if (mode < 70)
            size = layout + ($urandom_range(0, 1) ? $urandom_range(1, 4) : 0);
        else if (mode < 85)
            size = (layout > 1) ? $urandom_range(1, layout - 1) : 1;
        else if (mode < 92)
            size = 0;
        else
            size = $urandom_range(1, layout + 8);
        push_byte(nthr[BYTE_W-1:0]);
        push_byte(size[15:8]);
        push_byte(size[7:0]);
        for (int k = 0; k < size; k++)
        begin
            if ($urandom_range(0, 99) == 0)
                write_mode(1'($urandom_range(0, 1)));
            if (mode < 92 && k < nthr)
                b = pc[k][BYTE_W-1:0];
            else
                b = BYTE_W'($urandom_range(0, 255));
            push_byte(b);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("item_kind", 32'(want.kind), 32'(item_kind));
                    check_field("value", 32'(want.value), 32'(value));
                    check_field("slot", 32'(want.slot), 32'(slot));
                    check_field("polygon", 32'(want.polygon), 32'(polygon));
                    check_field("component", 32'(want.component), 32'(component));
                    check_field("record_end", 32'(want.record_end), 32'(record_end));
                    check_field("short_record", 32'(want.short_record),
                                32'(short_record));
                end
                if ($urandom_range(0, 99) == 0)
                    rx_calm = !rx_calm;
                hold = rx_calm ? 0 : $urandom_range(0, 15);
                stall_left <= hold;
                out_stall <= (hold != 0);
            end
            else if (stall_left > 1)
                stall_left <= stall_left - 1;
            else
            begin
                stall_left <= 0;
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        out_stall = 1'b0;
        for (int i = 0; i < MAX_THRESHOLDS; i++)
        begin
            poly_counts[i] = '0;
            has_polys[i] = 1'b0;
        end
        plan = '{
            '{8'h80, 1'b1, mk(KIND_RUN,     8'h00, 1'b1, 1'b0)},
            '{8'hff, 1'b1, mk(KIND_RUN,     8'h7f, 1'b1, 1'b0)},
            '{8'h05, 1'b1, mk(KIND_HEADER,  8'h05, 1'b0, 1'b0)},
            '{8'h00, 1'b1, mk(KIND_SIZE,    8'h00, 1'b0, 1'b0)},
            '{8'h00, 1'b1, mk(KIND_ZERO,    8'h00, 1'b1, 1'b1)},
            '{8'h00, 1'b1, mk(KIND_HEADER,  8'h00, 1'b0, 1'b0)},
            '{8'h00, 1'b1, mk(KIND_SIZE,    8'h00, 1'b0, 1'b0)},
            '{8'h00, 1'b1, mk(KIND_ZERO,    8'h00, 1'b1, 1'b0)},
            '{8'h00, 1'b1, mk(KIND_HEADER,  8'h00, 1'b0, 1'b0)},
            '{8'h00, 1'b1, mk(KIND_SIZE,    8'h00, 1'b0, 1'b0)},
            '{8'h02, 1'b1, mk(KIND_SIZE,    8'h02, 1'b0, 1'b0)},
            '{8'haa, 1'b1, mk(KIND_SURPLUS, 8'haa, 1'b0, 1'b0)},
            '{8'h55, 1'b1, mk(KIND_SURPLUS, 8'h55, 1'b1, 1'b0)},
            '{8'h7f, 1'b1, mk(KIND_HEADER,  8'h7f, 1'b0, 1'b0)},
            '{8'h00, 1'b1, mk(KIND_SIZE,    8'h00, 1'b0, 1'b0)},
            '{8'h02, 1'b1, mk(KIND_SIZE,    8'h02, 1'b0, 1'b0)},
            '{8'h00, 1'b0, '0},
            '{8'hff, 1'b0, '0},
            '{8'h01, 1'b1, mk(KIND_HEADER,  8'h01, 1'b0, 1'b0)},
            '{8'h00, 1'b1, mk(KIND_SIZE,    8'h00, 1'b0, 1'b0)},
            '{8'h05, 1'b1, mk(KIND_SIZE,    8'h05, 1'b0, 1'b0)},
            '{8'h02, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h3c, 1'b0, '0},
            '{8'hc3, 1'b0, '0},
            '{8'ha5, 1'b0, '0}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);
        for (int i = 0; i < PLAN_LEN; i++)
            push_byte(plan[i].b, plan[i].typed, plan[i].r);
        write_mode(1'b1);
        while (items_sent < ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                tx_calm = !tx_calm;
            case ($urandom_range(0, 19))
                0:       write_mode(1'($urandom_range(0, 1)));
                1, 2, 3: push_byte(RUN_MARK | BYTE_W'($urandom_range(0, 127)));
                default: send_record();
            endcase
        end
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
